// ===== hw/rtl/lsk_pkg.sv =====
// Shared types, op codes and default sizes of the linear-search key/value table.
package lsk_pkg;

  // Fixed field widths of the request and result items.
  localparam int unsigned OP_W    = 3;
  localparam int unsigned FIELD_W = 32;
  localparam int unsigned IDX_W   = 4;
  localparam int unsigned CNT_W   = 5;

  // Default sizes handed to the top level.
  localparam int unsigned ENTRIES_DEF     = 16;
  localparam int unsigned KEY_WIDTH_DEF   = 32;
  localparam int unsigned VALUE_WIDTH_DEF = 32;

  // Operation codes; codes above OP_CLEAR leave the table unchanged.
  localparam logic [OP_W-1:0] OP_LOOKUP        = 3'd0;
  localparam logic [OP_W-1:0] OP_LOOKUP_INSERT = 3'd1;
  localparam logic [OP_W-1:0] OP_WRITE         = 3'd2;
  localparam logic [OP_W-1:0] OP_KEY_AT        = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR         = 3'd4;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [FIELD_W-1:0] key;
    logic [FIELD_W-1:0] value_in;
    logic [IDX_W-1:0]   index;
  } req_t;

  typedef struct packed {
    logic [FIELD_W-1:0] value_out;
    logic               found;
    logic               inserted;
    logic               full_error;
    logic [FIELD_W-1:0] key_out;
    logic [CNT_W-1:0]   entry_count;
  } rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic advance;
    logic done_search;
    logic done_index;
    logic done_other;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic hit;
    logic scan_end;
  } sts_t;

endpackage

// ===== hw/rtl/lsk_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module lsk_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== hw/rtl/lsk_ctrl.sv =====
// Sequencing state machine of the key/value table.
module lsk_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  input  logic [lsk_pkg::OP_W-1:0]  op_i,
  input  lsk_pkg::sts_t             sts_i,
  output lsk_pkg::cmd_t             cmd_o,
  output logic                      busy,
  output logic                      done_o
);
  import lsk_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_INDEX,
    ST_OTHER
  } state_e;

  state_e state_q;
  logic   done_q;
  logic   accept;
  logic   search_end;

  assign busy       = (state_q != ST_IDLE);
  assign accept     = start && !busy;
  assign search_end = sts_i.hit || sts_i.scan_end;

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      ST_IDLE:   cmd_o.load = start;
      ST_SEARCH: begin
        cmd_o.done_search = search_end;
        cmd_o.advance     = !search_end;
      end
      ST_INDEX:  cmd_o.done_index = 1'b1;
      ST_OTHER:  cmd_o.done_other = 1'b1;
      default:   cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (start) begin
            if (op_i == OP_LOOKUP || op_i == OP_LOOKUP_INSERT || op_i == OP_WRITE) begin
              state_q <= ST_SEARCH;
            end else if (op_i == OP_KEY_AT) begin
              state_q <= ST_INDEX;
            end else begin
              state_q <= ST_OTHER;
            end
          end
        end
        ST_SEARCH: begin
          if (search_end) begin
            state_q <= ST_IDLE;
            done_q  <= 1'b1;
          end
        end
        ST_INDEX, ST_OTHER: begin
          state_q <= ST_IDLE;
          done_q  <= 1'b1;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign done_o = done_q;

`ifndef SYNTHESIS
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q) else $error("result strobe held for more than one cycle");
  a_done_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(state_q != ST_IDLE)) else $error("result strobe without a request");
  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy) else $error("accepted request did not start work");
`endif

endmodule

// ===== hw/rtl/lsk_datapath.sv =====
// Request registers, key/value stores, scan pointer and result register.
module lsk_datapath #(
  parameter int unsigned ENTRIES     = lsk_pkg::ENTRIES_DEF,
  parameter int unsigned KEY_WIDTH   = lsk_pkg::KEY_WIDTH_DEF,
  parameter int unsigned VALUE_WIDTH = lsk_pkg::VALUE_WIDTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  lsk_pkg::req_t                req_i,
  input  lsk_pkg::cmd_t                cmd_i,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [lsk_pkg::FIELD_W-1:0]  cfg_data_i,
  output lsk_pkg::sts_t                sts_o,
  output lsk_pkg::rsp_t                rsp_o
);
  import lsk_pkg::*;

  localparam int unsigned AW   = $clog2(ENTRIES);
  localparam int unsigned CW   = $clog2(ENTRIES + 1);
  localparam int unsigned KEXT = (KEY_WIDTH > FIELD_W) ? KEY_WIDTH : FIELD_W;
  localparam int unsigned VEXT = (VALUE_WIDTH > FIELD_W) ? VALUE_WIDTH : FIELD_W;
  localparam int unsigned IEXT = (CW > IDX_W) ? CW : IDX_W;
  localparam int unsigned CEXT = (CW > CNT_W) ? CW : CNT_W;
  localparam logic [CW-1:0] FULL_COUNT = CW'(ENTRIES);

  req_t                   req_q;
  rsp_t                   rsp_q, rsp_d;
  logic [CW-1:0]          ptr_q, ptr_d;
  logic [CW-1:0]          count_q, count_d;
  logic [FIELD_W-1:0]     dflt_q;

  logic [KEXT-1:0]        key_in_ext, key_rd_ext;
  logic [KEY_WIDTH-1:0]   key_w, key_rdata;
  logic [VEXT-1:0]        val_in_ext, dflt_ext, res_val_ext;
  logic [VALUE_WIDTH-1:0] val_w, dflt_w, val_rdata, wr_val_w, res_val_w;
  logic [IEXT-1:0]        idx_in_ext, idx_q_ext, cnt_iext;
  logic [CEXT-1:0]        cnt_ext;
  logic [CW-1:0]          idx_ptr;

  logic in_list, hit, room, is_write, is_lookup;
  logic key_we, val_we;

  // Fit the fixed-width fields to the storage widths.
  assign key_in_ext  = KEXT'(req_q.key);
  assign key_w       = key_in_ext[KEY_WIDTH-1:0];
  assign key_rd_ext  = KEXT'(key_rdata);
  assign val_in_ext  = VEXT'(req_q.value_in);
  assign val_w       = val_in_ext[VALUE_WIDTH-1:0];
  assign dflt_ext    = VEXT'(dflt_q);
  assign dflt_w      = dflt_ext[VALUE_WIDTH-1:0];
  assign idx_in_ext  = IEXT'(req_i.index);
  assign idx_ptr     = idx_in_ext[CW-1:0];
  assign idx_q_ext   = IEXT'(req_q.index);
  assign cnt_iext    = IEXT'(count_q);

  assign is_write  = (req_q.op == OP_WRITE);
  assign is_lookup = (req_q.op == OP_LOOKUP);
  assign in_list   = (ptr_q < count_q);
  assign hit       = in_list && (key_rdata == key_w);
  assign room      = (count_q != FULL_COUNT);

  assign sts_o.hit      = hit;
  assign sts_o.scan_end = !in_list;

  assign wr_val_w  = is_write ? val_w : dflt_w;
  assign res_val_w = hit ? (is_write ? val_w : val_rdata)
                         : (is_write ? ((room && !is_lookup) ? val_w : '0) : dflt_w);
  assign res_val_ext = VEXT'(res_val_w);

  // Append on a miss with room, update the value on a write hit.
  assign key_we = cmd_i.done_search && !hit && !is_lookup && room;
  assign val_we = cmd_i.done_search && (hit ? is_write : (!is_lookup && room));

  always_comb begin
    ptr_d = ptr_q;
    if (cmd_i.load) begin
      ptr_d = (req_i.op == OP_KEY_AT) ? idx_ptr : '0;
    end else if (cmd_i.advance) begin
      ptr_d = ptr_q + CW'(1);
    end
  end

  always_comb begin
    count_d = count_q;
    if (key_we) begin
      count_d = count_q + CW'(1);
    end else if (cmd_i.done_other && req_q.op == OP_CLEAR) begin
      count_d = '0;
    end
  end

  assign cnt_ext = CEXT'(count_d);

  always_comb begin
    rsp_d = rsp_q;
    if (cmd_i.done_search || cmd_i.done_index || cmd_i.done_other) begin
      rsp_d             = '0;
      rsp_d.entry_count = cnt_ext[CNT_W-1:0];
    end
    if (cmd_i.done_search) begin
      rsp_d.value_out  = res_val_ext[FIELD_W-1:0];
      rsp_d.found      = hit;
      rsp_d.inserted   = key_we;
      rsp_d.full_error = !hit && !is_lookup && !room;
    end
    if (cmd_i.done_index && (idx_q_ext < cnt_iext)) begin
      rsp_d.found   = 1'b1;
      rsp_d.key_out = key_rd_ext[FIELD_W-1:0];
    end
  end

  // Both stores share the read address; read data lines up with ptr_q.
  lsk_ram #(
    .WIDTH (KEY_WIDTH),
    .DEPTH (ENTRIES)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (ptr_q[AW-1:0]),
    .wdata_i (key_w),
    .raddr_i (ptr_d[AW-1:0]),
    .rdata_o (key_rdata)
  );

  lsk_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (ENTRIES)
  ) u_val_ram (
    .clk_i   (clk_i),
    .we_i    (val_we),
    .waddr_i (ptr_q[AW-1:0]),
    .wdata_i (wr_val_w),
    .raddr_i (ptr_d[AW-1:0]),
    .rdata_o (val_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= req_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q   <= '0;
      count_q <= '0;
      dflt_q  <= '0;
      rsp_q   <= '0;
    end else begin
      ptr_q   <= ptr_d;
      count_q <= count_d;
      rsp_q   <= rsp_d;
      if (cfg_valid_i) begin
        dflt_q <= cfg_data_i;
      end
    end
  end

  assign cfg_ready_o = 1'b1;
  assign rsp_o       = rsp_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FULL_COUNT) else $error("entry count above table size");
  a_insert_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_q.inserted |-> (!rsp_q.found && !rsp_q.full_error))
    else $error("insert flagged together with hit or full");
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_q.full_error |-> (count_q == FULL_COUNT))
    else $error("full flagged while table has room");
`endif

endmodule

// ===== hw/rtl/linear_search_key_value_table.sv =====
// Search: a search request compares stored keys from index 0 until a hit or, on a
//   miss, until it passes the last stored entry; done_o pulses in the cycle after the
//   last search step. Requests are taken only while idle; key_at_index, clear and
//   unknown ops skip the walk. The next request is taken in the cycle done_o pulses.
// Reset: table empty, default value zero; stores hold no reset state.
// The receiver cannot stall: done_o is high for exactly one cycle per result, and rsp_o holds until the next one.
module linear_search_key_value_table #(
  parameter int unsigned ENTRIES     = lsk_pkg::ENTRIES_DEF,
  parameter int unsigned KEY_WIDTH   = lsk_pkg::KEY_WIDTH_DEF,
  parameter int unsigned VALUE_WIDTH = lsk_pkg::VALUE_WIDTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // request channel
  input  logic                         start,
  output logic                         busy,
  input  lsk_pkg::req_t                req_i,
  // result channel
  output logic                         done_o,
  output lsk_pkg::rsp_t                rsp_o,
  // default value register write channel
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [lsk_pkg::FIELD_W-1:0]  cfg_data_i
);
  import lsk_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Controller: accept a request, walk the search one entry per cycle,
  // pulse the result strobe when the datapath has settled the outcome.
  lsk_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .op_i   (req_i.op),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy   (busy),
    .done_o (done_o)
  );

  // Datapath: hold the request, compare one stored key per cycle against
  // it, update or append at the end of the walk, and register the result.
  lsk_datapath #(
    .ENTRIES     (ENTRIES),
    .KEY_WIDTH   (KEY_WIDTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .cmd_i       (cmd),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .sts_o       (sts),
    .rsp_o       (rsp_o)
  );

endmodule
